// ----- src/mfc_pkg.sv -----
// Shared types and constants for the matched filter correlator.
// No dependencies.
package mfc_pkg;

	localparam int OP_W        = 2;
	localparam int TAP_IDX_W   = 6;
	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = 32;
	localparam int LEN_W       = 7;
	localparam int RECIP_W     = 32;
	localparam int CORR_W      = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int DIGIT_W     = 16;
	localparam int SCALE_SHIFT = 24;

	localparam logic [LEN_W-1:0]   REF_LENGTH_RST = 7'd64;
	localparam logic [CORR_W-1:0]  CORR_MAX       = 32'h7FFF_FFFF;
	localparam logic [CORR_W-1:0]  CORR_MIN       = 32'h8000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_REF_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_RECIP = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAC   = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// one tap-walk step handed to the multiply-accumulate
	typedef struct packed {
		logic issue;
		logic last;
		logic ok;
	} mac_ctl_t;

endpackage

// ----- src/mfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/mfc_mac.sv -----
// Multiply-accumulate over the tap walk: aligns control to RAM read data,
// one registered 16x16 product per cycle, wide accumulator. Uses mfc_pkg.
module mfc_mac #(
	parameter int ACC_W = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  mfc_pkg::mac_ctl_t                   ctl,
	input  logic signed [mfc_pkg::SAMPLE_W-1:0] tap,
	input  logic signed [mfc_pkg::SAMPLE_W-1:0] sample,
	output logic signed [ACC_W-1:0]             acc,
	output logic                                done
);

	import mfc_pkg::*;

	mac_ctl_t                  ctl_s1;
	logic                      vld_s2;
	logic                      last_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			ctl_s1  <= ctl;
			vld_s2  <= ctl_s1.issue;
			last_s2 <= ctl_s1.issue && ctl_s1.last;
			done_q  <= vld_s2 && last_s2;
		end
	end

	// unwritten history slots read as zero
	always_ff @(posedge clk) begin
		prod_s2 <= ctl_s1.ok ? PROD_W'(tap * sample) : '0;
		if (clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ----- src/mfc_scale.sv -----
// Normalizer: |acc| times the energy reciprocal, one 16-bit digit per cycle,
// then round half away from zero, shift by 24 and saturate. Uses mfc_pkg.
module mfc_scale #(
	parameter int ACC_W = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ACC_W-1:0]           acc,
	input  logic [mfc_pkg::RECIP_W-1:0]       recip,
	output logic                              done,
	output logic signed [mfc_pkg::CORR_W-1:0] result
);

	import mfc_pkg::*;

	localparam int DIGITS = (ACC_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MAG_W  = DIGITS * DIGIT_W;
	localparam int SUM_W  = MAG_W + RECIP_W;
	localparam int QW     = SUM_W + 1 - SCALE_SHIFT;
	localparam int RW     = $clog2(DIGITS + 1);
	localparam int PW     = DIGIT_W + RECIP_W;

	logic [ACC_W-1:0]  acc_u;
	logic [ACC_W-1:0]  abs_v;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic [RW-1:0]     rem_q;
	logic              run_q;
	logic [PW-1:0]     prod_s1;
	logic              pv_s1;
	logic              plast_s1;
	logic [SUM_W-1:0]  sum_q;
	logic              fin_q;
	logic              done_q;
	logic [CORR_W-1:0] result_q;
	logic [SUM_W:0]    rnd;
	logic [QW-1:0]     quo;
	logic              ovf_p;
	logic              ovf_n;
	logic [CORR_W-1:0] res_d;

	assign acc_u = acc;
	assign abs_v = acc_u[ACC_W-1] ? (~acc_u + ACC_W'(1)) : acc_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			rem_q    <= '0;
			pv_s1    <= 1'b0;
			plast_s1 <= 1'b0;
			fin_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			pv_s1    <= run_q;
			plast_s1 <= run_q && (rem_q == '0);
			fin_q    <= pv_s1 && plast_s1;
			done_q   <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				rem_q <= RW'(DIGITS - 1);
			end else if (run_q) begin
				rem_q <= rem_q - RW'(1);
				if (rem_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// most significant digit first, so the sum shifts by a constant
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= MAG_W'(abs_v);
			neg_q <= acc_u[ACC_W-1];
			sum_q <= '0;
		end else begin
			if (run_q) begin
				prod_s1 <= PW'(mag_q[MAG_W-1 -: DIGIT_W]) * PW'(recip);
				mag_q   <= mag_q << DIGIT_W;
			end
			if (pv_s1) begin
				sum_q <= (sum_q << DIGIT_W) + SUM_W'(prod_s1);
			end
		end
		if (fin_q) begin
			result_q <= res_d;
		end
	end

	always_comb begin
		rnd   = (SUM_W + 1)'(sum_q) + ((SUM_W + 1)'(1) << (SCALE_SHIFT - 1));
		quo   = rnd[SUM_W:SCALE_SHIFT];
		ovf_p = |quo[QW-1:CORR_W-1];
		ovf_n = (|quo[QW-1:CORR_W]) || (quo[CORR_W-1] && (|quo[CORR_W-2:0]));
		if (neg_q) begin
			res_d = ovf_n ? CORR_MIN : (~quo[CORR_W-1:0] + CORR_W'(1));
		end else begin
			res_d = ovf_p ? CORR_MAX : quo[CORR_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- src/matched_filter_correlator.sv -----
// Matched filter correlator top: tap and history RAMs, tap-walk sequencer,
// MAC and normalizer. Uses mfc_pkg, mfc_ram, mfc_mac, mfc_scale.
// Load and clear items are handled in the idle state. A push or flush item
// runs the tap walk, one tap and one history read per cycle into one MAC, then
// the normalizer; in_stall holds new items off until its result is registered.
// Reset: P = 64, reciprocal 0, history empty (reads zero), taps undefined.
module matched_filter_correlator #(
	parameter int MAX_TAPS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mfc_pkg::OP_W-1:0]            operation,
	input  logic [mfc_pkg::TAP_IDX_W-1:0]       tap_index,
	input  logic signed [mfc_pkg::SAMPLE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mfc_pkg::CORR_W-1:0]   corr_value
);

	import mfc_pkg::*;

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int PW    = $clog2(MAX_TAPS + 1);
	localparam int LW    = (PW > LEN_W) ? PW : LEN_W;
	localparam int ACC_W = 32 + $clog2(MAX_TAPS);
	localparam int XW    = AW + TAP_IDX_W;

	state_t              state_q;
	logic [LEN_W-1:0]    ref_length_q;
	logic [RECIP_W-1:0]  norm_recip_q;
	logic [AW-1:0]       head_q;
	logic                full_q;
	logic [AW-1:0]       tap_j_q;
	logic [AW-1:0]       slot_q;
	logic [PW-1:0]       cnt_q;
	logic                nz_q;
	logic                out_valid_q;
	logic [CORR_W-1:0]   corr_q;

	logic                accept;
	op_t                 op;
	logic                is_sample;
	logic [LW-1:0]       rl_ext;
	logic [LW-1:0]       p_sat;
	logic [PW-1:0]       p_len;
	logic [AW-1:0]       head_next;
	logic [AW+1:0]       start_sum;
	logic [AW-1:0]       start_slot;
	logic [XW-1:0]       tidx_ext;
	logic                tap_we;
	logic                hist_we;
	logic [SAMPLE_W-1:0] hist_wdata;
	logic                walk;
	mac_ctl_t            mac_ctl;
	logic [SAMPLE_W-1:0] tap_rd;
	logic [SAMPLE_W-1:0] hist_rd;
	logic signed [ACC_W-1:0] mac_acc;
	logic                mac_done;
	logic                scale_start;
	logic                scale_done;
	logic signed [CORR_W-1:0] scale_res;
	logic                out_load;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign op        = op_t'(operation);
	assign is_sample = (op == OP_PUSH) || (op == OP_FLUSH);

	assign rl_ext = LW'(ref_length_q);
	assign p_sat  = (rl_ext > LW'(MAX_TAPS)) ? LW'(MAX_TAPS) : rl_ext;
	assign p_len  = p_sat[PW-1:0];

	assign head_next  = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
	assign start_sum  = (AW + 2)'(head_next) + (AW + 2)'(MAX_TAPS) - (AW + 2)'(p_len);
	assign start_slot = (start_sum >= (AW + 2)'(MAX_TAPS)) ?
	                    AW'(start_sum - (AW + 2)'(MAX_TAPS)) : AW'(start_sum);

	assign tidx_ext   = XW'(tap_index);
	assign tap_we     = accept && (op == OP_LOAD) && (tidx_ext < XW'(MAX_TAPS));
	assign hist_we    = accept && is_sample;
	assign hist_wdata = (op == OP_FLUSH) ? '0 : value;

	// one issue even for P = 0, forced to a zero product
	assign walk          = (state_q == ST_MAC);
	assign mac_ctl.issue = walk;
	assign mac_ctl.last  = (cnt_q == '0);
	assign mac_ctl.ok    = nz_q && (full_q || (slot_q < head_q));

	assign scale_start = (state_q == ST_WAIT) && mac_done;
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_length_q <= REF_LENGTH_RST;
			norm_recip_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REF_LENGTH: ref_length_q <= cfg_data[LEN_W-1:0];
				CFG_NORM_RECIP: norm_recip_q <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			full_q      <= 1'b0;
			tap_j_q     <= '0;
			slot_q      <= '0;
			cnt_q       <= '0;
			nz_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_CLEAR: begin
								head_q <= '0;
								full_q <= 1'b0;
							end
							OP_PUSH, OP_FLUSH: begin
								head_q  <= head_next;
								if (head_next == '0) begin
									full_q <= 1'b1;
								end
								tap_j_q <= '0;
								slot_q  <= start_slot;
								cnt_q   <= (p_len == '0) ? '0 : p_len - PW'(1);
								nz_q    <= (p_len != '0);
								state_q <= ST_MAC;
							end
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					tap_j_q <= tap_j_q + AW'(1);
					slot_q  <= (slot_q == AW'(MAX_TAPS - 1)) ? '0 : slot_q + AW'(1);
					cnt_q   <= cnt_q - PW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (scale_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			corr_q <= scale_res;
		end
	end

	mfc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tidx_ext[AW-1:0]),
		.wdata (value),
		.re    (walk),
		.raddr (tap_j_q),
		.rdata (tap_rd)
	);

	mfc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (head_q),
		.wdata (hist_wdata),
		.re    (walk),
		.raddr (slot_q),
		.rdata (hist_rd)
	);

	mfc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (hist_we),
		.ctl    (mac_ctl),
		.tap    (tap_rd),
		.sample (hist_rd),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	mfc_scale #(
		.ACC_W (ACC_W)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.acc    (mac_acc),
		.recip  (norm_recip_q),
		.done   (scale_done),
		.result (scale_res)
	);

	assign out_valid  = out_valid_q;
	assign corr_value = corr_q;

`ifndef SYNTHESIS
	a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_WAIT))
		else $error("MAC finished outside the wait state");

	a_scale_done_in_scale: assert property (@(posedge clk) disable iff (!arst_n)
		scale_done |-> (state_q == ST_SCALE))
		else $error("normalizer finished outside the scale state");

	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result item raised without a finished correlation");
`endif

endmodule
